### design/tena_pkg.sv
package tena_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_BITS_DEF = 64;

  localparam int IN_W = 32;
  localparam int NUM_IN = 12;
  localparam int CNT_W = 24;
  localparam int ADDR_W = 3;
  localparam int DVD_W = 128;
  localparam int DSR_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [63:0] GRAD_CAP = 64'h0000_0100_0000_0000;
  localparam logic [31:0] ERR_CAP = 32'hFFFF_FFFF;

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_MIN_AREA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_DET, ST_DIVX, ST_DIVY,
    ST_WGT, ST_FIN, ST_SQ0, ST_SQ1, ST_SQ2, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    logic [63:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### design/tena_div.sv
module tena_div (
  input  logic               clk,
  input  logic               rst,
  input  tena_pkg::div_req_t req,
  output tena_pkg::div_rsp_t rsp
);

  logic busy;
  logic done;
  logic [6:0] cnt;
  logic [tena_pkg::DVD_W-1:0] dvd;
  logic [tena_pkg::DSR_W-1:0] dsr;
  logic [63:0] rem;
  logic [63:0] quot;
  logic ovf;
  logic [63:0] rs;
  logic ge;

  assign rs = {rem[62:0], dvd[tena_pkg::DVD_W-1]};
  assign ge = (rs >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quot <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[tena_pkg::DVD_W-2:0], 1'b0};
      rem <= ge ? rs - dsr : rs;
      quot <= {quot[62:0], ge};
      ovf <= ovf | quot[63];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.ovf = ovf;
  assign rsp.quot = quot;

endmodule

### design/tena_isqrt.sv
module tena_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  tena_pkg::sqrt_req_t req,
  output tena_pkg::sqrt_rsp_t rsp
);

  logic busy;
  logic done;
  logic [4:0] cnt;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] t;
  logic ge;

  assign t = res + bitm;
  assign ge = (v >= t);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      v <= req.value;
      res <= '0;
      bitm <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (ge) begin
        v <= v - t;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = res[31:0];

endmodule

### design/triangle_error_norm_accumulator_top.sv
// Triangle error-norm accumulator.
// The input stream carries one triangle per item on s_tdata: x0, y0, x1, y1, x2, y2,
// u0, u1, u2, exact value and exact gradient x and y at the centroid, 32 bits each.
// Each triangle adds its area-weighted value and gradient errors to two sums. After
// triangle_count triangles one result leaves on the output stream with the square roots
// of the L2, H1-seminorm and H1 sums, the skipped-triangle count and the overflow flag.
// Registers sit on the APB port: triangle_count at 0x0, min_double_area at 0x4.
// A degenerate triangle is counted as skipped and adds nothing to the sums. Any other
// triangle runs two 128-step restoring divisions on one shared divider, with a shared
// 32x32 multiplier doing the products. An item that closes a run adds three 32-step
// square roots.
// s_tready is high only while the block is idle, so one item is in work at a time.
// A finished result waits in the output register; the block keeps accepting items
// and stalls only when a new result is ready before the old one has been taken.
// Reset clears the sums, counters and overflow flag, sets triangle_count and
// min_double_area to one and drops m_tvalid.
module triangle_error_norm_accumulator_top #(
  parameter int COORD_BITS = tena_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = tena_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS = tena_pkg::ACC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // x0, y0, x1, y1, x2, y2, u0, u1, u2, exact_value, exact_grad_x, exact_grad_y
  input  logic [tena_pkg::NUM_IN*tena_pkg::IN_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // l2_error, h1_semi_error, h1_error, skipped_triangles
  output logic [119:0]                      m_tdata,
  // overflow
  output logic                              m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tena_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic signed [32:0] D_HI = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] D_LO = -(33'sd1 <<< (COORD_BITS - 1));
  localparam int SH = 2 * FRAC_BITS + 1;
  localparam int SHW = SH + 64;
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
  localparam logic [63:0] ACC_MAX64 = 64'(ACC_MAX);
  localparam logic [35:0] RECIP3 = 36'h5_5555_5556;

  tena_pkg::state_t state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [1:0] term;

  logic [tena_pkg::CNT_W-1:0] tri_count;
  logic [31:0] min_area;

  logic [ACC_BITS-1:0] value_sum;
  logic [ACC_BITS-1:0] grad_sum;
  logic [tena_pkg::CNT_W-1:0] tri_seen;
  logic [tena_pkg::CNT_W-1:0] deg_seen;
  logic saturated;

  logic signed [31:0] in_r [tena_pkg::NUM_IN];
  logic signed [31:0] diff_r [6];
  logic signed [31:0] diff_c [6];
  logic [5:0] diff_sat_c;
  logic signed [33:0] s_r;
  logic signed [63:0] prod_r [6];
  logic signed [63:0] det_c, numx_c, numy_c;
  logic signed [63:0] det_r, numx_r, numy_r;
  logic [63:0] adet_c, adet_r;
  logic degen_c;
  logic signed [33:0] uh_r;
  logic signed [41:0] gx_r, gy_r;

  logic [31:0] mul_a, mul_b;
  logic mul_neg;
  logic signed [31:0] sa, sb;
  logic [63:0] mul_p;
  logic mul_neg_r;
  logic [1:0] jw, ja;
  logic [63:0] mm_r;
  logic [127:0] acc128;

  logic signed [42:0] err_c;
  logic [42:0] err_mag_c;
  logic [31:0] m_c;
  logic err_sat_c;
  logic [63:0] r64_c;
  logic wsat_c;
  logic [ACC_BITS-1:0] w_c;
  logic [ACC_BITS:0] sum_c;
  logic [ACC_BITS:0] both_c;
  logic [ACC_BITS-1:0] both_r;
  logic both_ovf_r;

  logic [63:0] q_c;
  logic cap_c;
  logic gneg_c;
  logic signed [41:0] g_c;
  logic [34:0] s_plus_c;
  logic [53:0] qp_lo_r;
  logic [52:0] qp_hi_r;
  logic [71:0] q3_c;

  logic [31:0] l2_r, h1s_r, h1_r;

  tena_pkg::div_req_t div_req;
  tena_pkg::div_rsp_t div_rsp;
  tena_pkg::sqrt_req_t sqrt_req;
  tena_pkg::sqrt_rsp_t sqrt_rsp;

  tena_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  tena_isqrt u_isqrt (.clk(clk), .rst(rst), .req(sqrt_req), .rsp(sqrt_rsp));

  function automatic logic [32:0] sat_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > D_HI) begin
      return {1'b1, D_HI[31:0]};
    end else if (d < D_LO) begin
      return {1'b1, D_LO[31:0]};
    end
    return {1'b0, d[31:0]};
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_count <= tena_pkg::CNT_W'(1);
      min_area <= 32'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        tena_pkg::REG_COUNT: tri_count <= pwdata[tena_pkg::CNT_W-1:0];
        tena_pkg::REG_MIN_AREA: min_area <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tena_pkg::REG_COUNT: prdata = 32'(tri_count);
      tena_pkg::REG_MIN_AREA: prdata = min_area;
      default: prdata = '0;
    endcase
  end

  // Edge differences, saturated to the coordinate range.
  always_comb begin
    logic [32:0] r [6];
    r[0] = sat_diff(in_r[2], in_r[0]);
    r[1] = sat_diff(in_r[3], in_r[1]);
    r[2] = sat_diff(in_r[4], in_r[0]);
    r[3] = sat_diff(in_r[5], in_r[1]);
    r[4] = sat_diff(in_r[7], in_r[6]);
    r[5] = sat_diff(in_r[8], in_r[6]);
    for (int i = 0; i < 6; i++) begin
      diff_c[i] = r[i][31:0];
      diff_sat_c[i] = r[i][32];
    end
  end

  assign det_c = prod_r[0] - prod_r[1];
  assign numx_c = prod_r[2] - prod_r[3];
  assign numy_c = prod_r[4] - prod_r[5];
  assign adet_c = tena_pkg::mag64(det_c);
  assign degen_c = (det_c == 64'sd0) || (adet_c < 64'(min_area));
  assign s_plus_c = (s_r[33] ? 35'(-s_r) : 35'(s_r)) + 35'd1;

  // The vertex mean divides by three through a reciprocal multiply in two halves.
  assign q3_c = (72'(qp_hi_r) << 18) + 72'(qp_lo_r);

  // Quotient cap and sign for the gradient divisions.
  assign q_c = div_rsp.quot;
  assign cap_c = div_rsp.ovf || (q_c > tena_pkg::GRAD_CAP);
  assign gneg_c = (state == tena_pkg::ST_DIVX) ? (numx_r[63] ^ det_r[63])
                                               : (numy_r[63] ^ det_r[63]);
  always_comb begin
    logic [41:0] gm;
    gm = cap_c ? 42'(tena_pkg::GRAD_CAP) : {1'b0, q_c[40:0]};
    g_c = gneg_c ? -$signed(gm) : $signed(gm);
  end

  // Error magnitude of the current term.
  always_comb begin
    case (term)
      2'd0: err_c = 43'(in_r[9]) - 43'(uh_r);
      2'd1: err_c = 43'(in_r[10]) - 43'(gx_r);
      default: err_c = 43'(in_r[11]) - 43'(gy_r);
    endcase
    err_mag_c = err_c[42] ? 43'(-err_c) : 43'(err_c);
    err_sat_c = (err_mag_c > 43'(tena_pkg::ERR_CAP));
    m_c = err_sat_c ? tena_pkg::ERR_CAP : err_mag_c[31:0];
  end

  assign r64_c = acc128[SH +: 64];
  assign wsat_c = ((acc128 >> SHW) != 128'd0) || (r64_c > ACC_MAX64);
  assign w_c = wsat_c ? ACC_MAX : r64_c[ACC_BITS-1:0];
  assign sum_c = {1'b0, (term == 2'd0) ? value_sum : grad_sum} + {1'b0, w_c};
  assign both_c = {1'b0, value_sum} + {1'b0, grad_sum};

  // Shared multiplier operand selection.
  assign jw = 2'(cnt - 3'd2);
  assign ja = 2'(cnt - 3'd3);

  always_comb begin
    sa = '0;
    sb = '0;
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    if (state == tena_pkg::ST_MUL) begin
      case (cnt)
        3'd0: begin sa = diff_r[0]; sb = diff_r[3]; end
        3'd1: begin sa = diff_r[2]; sb = diff_r[1]; end
        3'd2: begin sa = diff_r[4]; sb = diff_r[3]; end
        3'd3: begin sa = diff_r[5]; sb = diff_r[1]; end
        3'd4: begin sa = diff_r[5]; sb = diff_r[0]; end
        3'd5: begin sa = diff_r[4]; sb = diff_r[2]; end
        default: ;
      endcase
      mul_a = tena_pkg::mag32(sa);
      mul_b = tena_pkg::mag32(sb);
      mul_neg = sa[31] ^ sb[31];
    end else if (state == tena_pkg::ST_WGT) begin
      if (cnt == 3'd0) begin
        mul_a = m_c;
        mul_b = m_c;
      end else if (cnt >= 3'd2 && cnt <= 3'd5) begin
        mul_a = jw[1] ? adet_r[63:32] : adet_r[31:0];
        mul_b = jw[0] ? mm_r[63:32] : mm_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
    mul_neg_r <= mul_neg;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tena_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    div_req = '0;
    sqrt_req = '0;
    case (state)
      tena_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tena_pkg::ST_DIFF;
      end
      tena_pkg::ST_DIFF: begin
        state_next = tena_pkg::ST_MUL;
        cnt_next = '0;
      end
      tena_pkg::ST_MUL: begin
        if (cnt == 3'd6) state_next = tena_pkg::ST_DET;
        else cnt_next = cnt + 3'd1;
      end
      tena_pkg::ST_DET: begin
        if (degen_c) begin
          state_next = tena_pkg::ST_FIN;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = 128'(tena_pkg::mag64(numx_c)) << FRAC_BITS;
          div_req.divisor = adet_c;
          state_next = tena_pkg::ST_DIVX;
        end
      end
      tena_pkg::ST_DIVX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = 128'(tena_pkg::mag64(numy_r)) << FRAC_BITS;
          div_req.divisor = adet_r;
          state_next = tena_pkg::ST_DIVY;
        end
      end
      tena_pkg::ST_DIVY: begin
        if (div_rsp.done) begin
          state_next = tena_pkg::ST_WGT;
          cnt_next = '0;
        end
      end
      tena_pkg::ST_WGT: begin
        if (cnt == 3'd7) begin
          cnt_next = '0;
          if (term == 2'd2) state_next = tena_pkg::ST_FIN;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      tena_pkg::ST_FIN: begin
        if (tri_seen >= tri_count) begin
          sqrt_req.start = 1'b1;
          sqrt_req.value = 64'(value_sum);
          state_next = tena_pkg::ST_SQ0;
        end else begin
          state_next = tena_pkg::ST_IDLE;
        end
      end
      tena_pkg::ST_SQ0: begin
        if (sqrt_rsp.done) begin
          sqrt_req.start = 1'b1;
          sqrt_req.value = 64'(grad_sum);
          state_next = tena_pkg::ST_SQ1;
        end
      end
      tena_pkg::ST_SQ1: begin
        if (sqrt_rsp.done) begin
          sqrt_req.start = 1'b1;
          sqrt_req.value = 64'(both_r);
          state_next = tena_pkg::ST_SQ2;
        end
      end
      tena_pkg::ST_SQ2: begin
        if (sqrt_rsp.done) state_next = tena_pkg::ST_OUT;
      end
      tena_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = tena_pkg::ST_IDLE;
      end
      default: state_next = tena_pkg::ST_IDLE;
    endcase
  end

  assign s_tready = (state == tena_pkg::ST_IDLE);

  // Accumulators, counters and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_sum <= '0;
      grad_sum <= '0;
      tri_seen <= '0;
      deg_seen <= '0;
      saturated <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == tena_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        tena_pkg::ST_DIFF: begin
          if (|diff_sat_c) saturated <= 1'b1;
        end
        tena_pkg::ST_DET: begin
          tri_seen <= tri_seen + tena_pkg::CNT_W'(1);
          if (degen_c && deg_seen != tena_pkg::CNT_MAX) begin
            deg_seen <= deg_seen + tena_pkg::CNT_W'(1);
          end
        end
        tena_pkg::ST_DIVX, tena_pkg::ST_DIVY: begin
          if (div_rsp.done && cap_c) saturated <= 1'b1;
        end
        tena_pkg::ST_WGT: begin
          if (cnt == 3'd0 && err_sat_c) saturated <= 1'b1;
          if (cnt == 3'd7) begin
            if (wsat_c || sum_c[ACC_BITS]) saturated <= 1'b1;
            if (term == 2'd0) begin
              value_sum <= sum_c[ACC_BITS] ? ACC_MAX : sum_c[ACC_BITS-1:0];
            end else begin
              grad_sum <= sum_c[ACC_BITS] ? ACC_MAX : sum_c[ACC_BITS-1:0];
            end
          end
        end
        tena_pkg::ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            value_sum <= '0;
            grad_sum <= '0;
            tri_seen <= '0;
            deg_seen <= '0;
            saturated <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == tena_pkg::ST_IDLE && s_tvalid) begin
      for (int i = 0; i < tena_pkg::NUM_IN; i++) begin
        in_r[i] <= s_tdata[i*tena_pkg::IN_W +: tena_pkg::IN_W];
      end
    end
    if (state == tena_pkg::ST_DIFF) begin
      for (int i = 0; i < 6; i++) diff_r[i] <= diff_c[i];
      s_r <= 34'(in_r[6]) + 34'(in_r[7]) + 34'(in_r[8]);
    end
    if (state == tena_pkg::ST_MUL && cnt != 3'd0) begin
      prod_r[cnt - 3'd1] <= mul_neg_r ? -$signed(mul_p) : $signed(mul_p);
    end
    if (state == tena_pkg::ST_MUL && cnt == 3'd0) begin
      qp_lo_r <= 54'(s_plus_c[17:0]) * 54'(RECIP3);
    end
    if (state == tena_pkg::ST_MUL && cnt == 3'd1) begin
      qp_hi_r <= 53'(s_plus_c[34:18]) * 53'(RECIP3);
    end
    if (state == tena_pkg::ST_MUL && cnt == 3'd2) begin
      uh_r <= s_r[33] ? -$signed({2'b00, q3_c[67:36]}) : $signed({2'b00, q3_c[67:36]});
    end
    if (state == tena_pkg::ST_DET) begin
      det_r <= det_c;
      numx_r <= numx_c;
      numy_r <= numy_c;
      adet_r <= adet_c;
    end
    if (state == tena_pkg::ST_DIVX && div_rsp.done) gx_r <= g_c;
    if (state == tena_pkg::ST_DIVY && div_rsp.done) begin
      gy_r <= g_c;
      term <= 2'd0;
    end
    if (state == tena_pkg::ST_WGT) begin
      case (cnt)
        3'd0: acc128 <= '0;
        3'd1: mm_r <= mul_p;
        3'd3, 3'd4, 3'd5, 3'd6: begin
          case (2'(ja[1]) + 2'(ja[0]))
            2'd0: acc128 <= acc128 + 128'(mul_p);
            2'd1: acc128 <= acc128 + (128'(mul_p) << 32);
            default: acc128 <= acc128 + (128'(mul_p) << 64);
          endcase
        end
        3'd7: term <= term + 2'd1;
        default: ;
      endcase
    end
    if (state == tena_pkg::ST_FIN) begin
      both_r <= both_c[ACC_BITS] ? ACC_MAX : both_c[ACC_BITS-1:0];
      both_ovf_r <= both_c[ACC_BITS];
    end
    if (state == tena_pkg::ST_SQ0 && sqrt_rsp.done) l2_r <= sqrt_rsp.root;
    if (state == tena_pkg::ST_SQ1 && sqrt_rsp.done) h1s_r <= sqrt_rsp.root;
    if (state == tena_pkg::ST_SQ2 && sqrt_rsp.done) h1_r <= sqrt_rsp.root;
    if (state == tena_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {deg_seen, h1_r, h1s_r, l2_r};
      m_tuser <= saturated | both_ovf_r;
    end
  end

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!div_rsp.busy && !sqrt_rsp.busy))
    else $error("arithmetic unit busy while block is idle");

  a_deg_le_seen: assert property (@(posedge clk) disable iff (rst)
    deg_seen <= tri_seen)
    else $error("skipped count exceeds triangle count");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == tena_pkg::ST_OUT))
    else $error("result raised outside the output state");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
